// ===== rtl/msi_pkg.sv =====
package msi_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int NUM_SAMPLES  = 9;

  // rank counts go up to NUM_SAMPLES
  localparam int RANK_WIDTH   = $clog2(NUM_SAMPLES + 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef sample_t                        sample_arr_t [NUM_SAMPLES];
  typedef logic [NUM_SAMPLES-1:0]         lane_mask_t;
  typedef logic [RANK_WIDTH-1:0]          rank_t;

  // window_select codes
  typedef enum logic [1:0] {
    WIN_3 = 2'd0,
    WIN_5 = 2'd1,
    WIN_7 = 2'd2,
    WIN_9 = 2'd3
  } window_t;

  // samples taken into the window for each code
  function automatic lane_mask_t window_mask(window_t win);
    lane_mask_t m;
    unique case (win)
      WIN_3:   m = lane_mask_t'(9'b000000111);
      WIN_5:   m = lane_mask_t'(9'b000011111);
      WIN_7:   m = lane_mask_t'(9'b001111111);
      WIN_9:   m = lane_mask_t'(9'b111111111);
      default: m = lane_mask_t'(9'b111111111);
    endcase
    return m;
  endfunction

  // middle position of the sorted window: count / 2
  function automatic rank_t window_mid(window_t win);
    return rank_t'(win) + rank_t'(1);
  endfunction

endpackage

// ===== rtl/msi_if.sv =====
interface msi_in_if;
  import msi_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_0;
  sample_t sample_1;
  sample_t sample_2;
  sample_t sample_3;
  sample_t sample_4;
  sample_t sample_5;
  sample_t sample_6;
  sample_t sample_7;
  sample_t sample_8;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8,
    output ready
  );
endinterface

interface msi_out_if;
  import msi_pkg::*;

  logic    valid;
  logic    ready;
  sample_t median_value;

  modport source (output valid, median_value, input ready);
  modport sink (input valid, median_value, output ready);
endinterface

// ===== rtl/median_select_int.sv =====
// Median of a window of 3, 5, 7 or 9 signed samples, chosen by window_select
// (reset value selects 9). Samples beyond the window are ignored. One item is
// accepted per cycle unless stalled, and each gives exactly one result: nine
// lanes rank their own sample against the window in the first stage, and a
// merge stage picks a lane holding the median into the output register. A
// stalled output holds the lane stage; bubbles in either stage are filled.
// Write window_select only while no item is in flight.
module median_select_int (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_data,
  msi_in_if.sink          din,
  msi_out_if.source       dout
);
  import msi_pkg::*;

  window_t     window_select;
  sample_arr_t in_samples;
  lane_mask_t  active;
  rank_t       mid;
  lane_mask_t  lane_hit;
  sample_arr_t lane_value;
  sample_t     median;
  logic        lane_valid;
  logic        lane_adv;
  logic        in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_select <= WIN_9;
    end else if (cfg_we) begin
      window_select <= window_t'(cfg_data);
    end
  end

  assign in_samples[0] = din.sample_0;
  assign in_samples[1] = din.sample_1;
  assign in_samples[2] = din.sample_2;
  assign in_samples[3] = din.sample_3;
  assign in_samples[4] = din.sample_4;
  assign in_samples[5] = din.sample_5;
  assign in_samples[6] = din.sample_6;
  assign in_samples[7] = din.sample_7;
  assign in_samples[8] = din.sample_8;

  assign active = window_mask(window_select);
  assign mid    = window_mid(window_select);

  assign lane_adv  = !dout.valid || dout.ready;
  assign din.ready = !lane_valid || lane_adv;
  assign in_take   = din.valid && din.ready;

  for (genvar g = 0; g < NUM_SAMPLES; g++) begin : g_lane
    msi_lane u_lane (
      .clk        (clk),
      .en         (din.ready),
      .own_active (active[g]),
      .own_sample (in_samples[g]),
      .samples    (in_samples),
      .active     (active),
      .mid        (mid),
      .hit        (lane_hit[g]),
      .value      (lane_value[g])
    );
  end

  msi_merge u_merge (
    .hit    (lane_hit),
    .values (lane_value),
    .median (median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else if (din.ready) begin
      lane_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (lane_adv) begin
      dout.valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_adv && lane_valid) begin
      dout.median_value <= median;
    end
  end

  a_lane_fill: assert property (@(posedge clk) disable iff (rst)
    in_take |=> lane_valid)
    else $error("accepted beat did not reach the lane stage");

  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    lane_valid |-> lane_hit != '0)
    else $error("no lane found the median");

  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    lane_valid && lane_adv |=> dout.valid)
    else $error("lane stage beat lost before the output");

endmodule

// ===== rtl/msi_lane.sv =====
module msi_lane (
  input  logic                clk,
  input  logic                en,
  input  logic                own_active,
  input  msi_pkg::sample_t    own_sample,
  input  msi_pkg::sample_arr_t samples,
  input  msi_pkg::lane_mask_t active,
  input  msi_pkg::rank_t      mid,
  output logic                hit,
  output msi_pkg::sample_t    value
);
  import msi_pkg::*;

  rank_t below;
  rank_t not_above;
  logic  hit_next;

  // rank test of this lane's sample against every sample in the window
  always_comb begin
    below     = '0;
    not_above = '0;
    for (int j = 0; j < NUM_SAMPLES; j++) begin
      if (active[j]) begin
        below     = below + rank_t'(samples[j] < own_sample);
        not_above = not_above + rank_t'(samples[j] <= own_sample);
      end
    end
    hit_next = own_active && (below <= mid) && (not_above > mid);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit   <= hit_next;
      value <= own_sample;
    end
  end

endmodule

// ===== rtl/msi_merge.sv =====
module msi_merge (
  input  msi_pkg::lane_mask_t  hit,
  input  msi_pkg::sample_arr_t values,
  output msi_pkg::sample_t     median
);
  import msi_pkg::*;

  // lowest hitting lane wins; all hitting lanes hold equal values
  always_comb begin
    median = values[0];
    for (int i = NUM_SAMPLES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        median = values[i];
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  import msi_pkg::*;

  localparam sample_t S_MIN = sample_t'(1) << (SAMPLE_WIDTH - 1);
  localparam sample_t S_MAX = ~S_MIN;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 118;

  // expected medians of accepted windows, in order of acceptance
  class median_board;
    sample_t     medians[$];
    window_t     win;
    int unsigned errors;

    function new();
      win = WIN_9;
      errors = 0;
    endfunction

    function void note_window(sample_arr_t s);
      sample_t sorted[NUM_SAMPLES];
      sample_t t;
      int count;
      int j;
      count = 3 + 2 * int'(win);
      for (int i = 0; i < count; i++) begin
        sorted[i] = s[i];
      end
      // insertion sort in signed order over the used lanes only
      for (int i = 1; i < count; i++) begin
        t = sorted[i];
        j = i - 1;
        while (j >= 0 && sorted[j] > t) begin
          sorted[j + 1] = sorted[j];
          j--;
        end
        sorted[j + 1] = t;
      end
      medians.push_back(sorted[count / 2]);
    endfunction

    function void check_median(sample_t got);
      sample_t want;
      if (medians.size() == 0) begin
        errors++;
        if (errors <= 10) $display("median %0d with no window pending", got);
        return;
      end
      want = medians.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("median mismatch: expected %0d (%h), got %0d (%h)", want, want, got, got);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_data;
  logic       calm;
  int         stalled;

  msi_in_if  din();
  msi_out_if dout();

  median_board board = new();

  median_select_int u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .din      (din),
    .dout     (dout)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: stall at random unless in the calm stretch
  always @(posedge clk) begin
    dout.ready <= calm || ($urandom_range(99) >= 18);
  end

  // check results and watch for a hang
  always @(posedge clk) begin
    if (!rst && dout.valid && dout.ready) begin
      board.check_median(dout.median_value);
    end
    if ((din.valid && din.ready) || (dout.valid && dout.ready)) begin
      stalled <= 0;
    end else if (stalled >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  task automatic drive_samples(input sample_arr_t s);
    din.sample_0 <= s[0];
    din.sample_1 <= s[1];
    din.sample_2 <= s[2];
    din.sample_3 <= s[3];
    din.sample_4 <= s[4];
    din.sample_5 <= s[5];
    din.sample_6 <= s[6];
    din.sample_7 <= s[7];
    din.sample_8 <= s[8];
  endtask

  task automatic push_window(input sample_arr_t s);
    din.valid <= 1'b1;
    drive_samples(s);
    do @(posedge clk); while (!din.ready);
    board.note_window(s);
    if (!calm && $urandom_range(99) < 18) begin
      din.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // write the window only once the pipeline has drained
  task automatic set_window(input window_t w);
    din.valid <= 1'b0;
    while (board.medians.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.win = w;
  endtask

  function automatic sample_t pick_sample(int mode);
    sample_t v;
    case (mode)
      0: v = sample_t'($urandom);
      1: v = sample_t'(int'($urandom_range(8)) - 4);  // dense ties
      default: begin
        case ($urandom_range(4))
          0: v = S_MIN;
          1: v = S_MAX;
          2: v = '0;
          3: v = '1;
          default: v = sample_t'(1);
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    sample_arr_t s;
    window_t     plan [8];
    int          n;
    int          mode;

    plan = '{WIN_3, WIN_9, WIN_5, WIN_7, WIN_9, WIN_3, WIN_7, WIN_5};
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_data = '0;
    calm     = 1'b0;
    stalled  = 0;
    din.valid = 1'b0;
    dout.ready = 1'b0;
    for (int i = 0; i < NUM_SAMPLES; i++) s[i] = '0;
    drive_samples(s);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, ties and out-of-window lanes for every size
    for (int w = 0; w < 4; w++) begin
      set_window(window_t'(w));
      n = 3 + 2 * w;
      for (int k = 0; k < 5; k++) begin
        for (int i = 0; i < NUM_SAMPLES; i++) begin
          case (k)
            0: s[i] = S_MIN;
            1: s[i] = S_MAX;
            2: s[i] = (i % 2) ? S_MAX : S_MIN;
            3: s[i] = (i % 3 == 0) ? sample_t'(-1) : sample_t'(7);
            // lanes past the window would pull the median up if used
            default: s[i] = (i < n) ? sample_t'(n - 1 - i) : S_MAX;
          endcase
        end
        push_window(s);
      end
    end

    // random phases over all window sizes; one stretch runs without gaps
    for (int p = 0; p < 8; p++) begin
      set_window(plan[p]);
      calm = (p == 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        mode = $urandom_range(2);
        for (int i = 0; i < NUM_SAMPLES; i++) begin
          s[i] = pick_sample(($urandom_range(3) == 0) ? int'($urandom_range(2)) : mode);
        end
        push_window(s);
      end
    end
    calm = 1'b0;

    din.valid <= 1'b0;
    while (board.medians.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/msi_pkg.sv
rtl/msi_if.sv
rtl/msi_lane.sv
rtl/msi_merge.sv
rtl/median_select_int.sv
dv/tb.sv
